### rtl/core/kel_pkg.sv
// Package: shared types and constants for the keyed edge list table.
`timescale 1ns / 1ps
package kel_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 31;
  localparam int WGT_W    = 64;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;
  localparam int IN_W     = 104;
  localparam int OUT_W    = 72;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_WARN = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic             fire;
    func_t            op;
    logic [KEY_W-1:0] key;
    logic [WGT_W-1:0] weight;
    logic             add_ok;
    logic             rm_ok;
  } kel_req_t;

  typedef struct packed {
    logic occ;
    logic tail;
  } kel_slot_t;

endpackage

### rtl/core/kel_cell.sv
// One table entry: key and weight, key compare, neighbor shift on remove.
`timescale 1ns / 1ps
module kel_cell
  import kel_pkg::*;
(
  input  logic             clk,
  input  kel_req_t         req,
  input  kel_slot_t        slot,
  input  logic             prior_hit,
  input  logic [KEY_W-1:0] up_key,
  input  logic [WGT_W-1:0] up_weight,
  output logic             hit,
  output logic             chain_hit,
  output logic [KEY_W-1:0] key_o,
  output logic [WGT_W-1:0] weight_o
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [WGT_W-1:0] weight_r, weight_nxt;

  assign hit       = slot.occ && (key_r == req.key);
  assign chain_hit = prior_hit || hit;
  assign key_o     = key_r;
  assign weight_o  = weight_r;

  always_comb begin
    key_nxt    = key_r;
    weight_nxt = weight_r;
    if (req.fire) begin
      unique case (req.op)
        FUNC_ADD: begin
          if (req.add_ok && slot.tail) begin
            key_nxt    = req.key;
            weight_nxt = req.weight;
          end
        end
        FUNC_UPDATE: begin
          if (hit) begin
            weight_nxt = req.weight;
          end
        end
        FUNC_REMOVE: begin
          if (req.rm_ok && chain_hit) begin
            key_nxt    = up_key;
            weight_nxt = up_weight;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    weight_r <= weight_nxt;
  end

endmodule

### rtl/core/keyed_edge_list_table_top.sv
// Top level: request register, row of entry cells, count and result register.
//
//  channel | dir | ports                       | accepted when
//  in      | in  | in_tvalid/in_tready/in_tdata | in_tvalid && in_tready
//  out     | out | out_tvalid/out_tready/out_tdata | out_tvalid && out_tready
//
//  A request is registered on accept and resolved by the cell row when the
//  output is free (all keys compared at once, shift by one place on remove).
//  One request per cycle while not stalled: request, then result register.
//  Reset clears the count and the valid flags; cell contents are left as is.
//  A stalled result holds the request register, which holds in_tready low.
`timescale 1ns / 1ps
module keyed_edge_list_table_top
  import kel_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // func[1:0], neighbor_key[32:2], new_weight[96:33]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status[1:0], previous_weight[65:2],
                                       // previous_valid[66], entry_count[71:67]
);

  logic             req_v_r;
  func_t            req_op_r;
  logic [KEY_W-1:0] req_key_r;
  logic [WGT_W-1:0] req_wgt_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  logic             proc_fire;
  logic             in_fire;
  logic             any_hit;
  logic             full;
  logic [WGT_W-1:0] prev_wgt;
  status_t          status;
  logic             pvalid;
  kel_req_t         req;

  logic [CAPACITY-1:0]  hit_v;
  logic [CAPACITY:0]    chain_v;
  logic [KEY_W-1:0]     key_v    [CAPACITY];
  logic [WGT_W-1:0]     weight_v [CAPACITY];
  kel_slot_t            slot_v   [CAPACITY];

  assign proc_fire = req_v_r && (!out_tvalid_r || out_tready);
  assign in_tready = !req_v_r || proc_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign any_hit = |hit_v;
  assign full    = (count_r == CNT_W'(CAPACITY));

  assign req.fire   = proc_fire;
  assign req.op     = req_op_r;
  assign req.key    = req_key_r;
  assign req.weight = req_wgt_r;
  assign req.add_ok = !any_hit && !full;
  assign req.rm_ok  = any_hit;

  assign chain_v[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign slot_v[i].occ  = (count_r > CNT_W'(i));
    assign slot_v[i].tail = (count_r == CNT_W'(i));

    if (i == CAPACITY - 1) begin : g_last
      kel_cell u_cell (
        .clk       (clk),
        .req       (req),
        .slot      (slot_v[i]),
        .prior_hit (chain_v[i]),
        .up_key    (key_v[i]),
        .up_weight (weight_v[i]),
        .hit       (hit_v[i]),
        .chain_hit (chain_v[i+1]),
        .key_o     (key_v[i]),
        .weight_o  (weight_v[i])
      );
    end else begin : g_mid
      kel_cell u_cell (
        .clk       (clk),
        .req       (req),
        .slot      (slot_v[i]),
        .prior_hit (chain_v[i]),
        .up_key    (key_v[i+1]),
        .up_weight (weight_v[i+1]),
        .hit       (hit_v[i]),
        .chain_hit (chain_v[i+1]),
        .key_o     (key_v[i]),
        .weight_o  (weight_v[i])
      );
    end
  end

  always_comb begin
    prev_wgt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      prev_wgt = prev_wgt | (weight_v[i] & {WGT_W{hit_v[i]}});
    end
  end

  always_comb begin
    status    = ST_WARN;
    pvalid    = 1'b0;
    count_nxt = count_r;
    unique case (req_op_r)
      FUNC_ADD: begin
        if (any_hit) begin
          status = ST_WARN;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status    = ST_OK;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_UPDATE: begin
        if (any_hit) begin
          status = ST_OK;
          pvalid = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (any_hit) begin
          status    = ST_OK;
          pvalid    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    out_tdata_nxt = {ECNT_W'(count_nxt), pvalid, prev_wgt & {WGT_W{pvalid}}, status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r      <= 1'b0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        req_v_r <= 1'b1;
      end else if (proc_fire) begin
        req_v_r <= 1'b0;
      end
      if (proc_fire) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op_r  <= func_t'(in_tdata[1:0]);
      req_key_r <= in_tdata[32:2];
      req_wgt_r <= in_tdata[96:33];
    end
    if (proc_fire) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    req_v_r |-> $onehot0(hit_v))
    else $error("key matched in more than one entry");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && req_op_r == FUNC_ADD && !any_hit && !full)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count not advanced after add");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && req_op_r == FUNC_REMOVE && any_hit)
      |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("count not dropped after remove");

endmodule

### test/testbench.sv
// Testbench for the keyed edge list table: random and directed edge requests checked per result.
`timescale 1ns / 1ps
module testbench;
  import kel_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam int POOL_N = 24;
  localparam int RANDOM_OPS = 550;

  typedef struct {
    func_t            func;
    logic [KEY_W-1:0] key;
    logic [WGT_W-1:0] weight;
    bit               wait_idle;
  } edge_op_t;

  typedef struct {
    status_t           status;
    logic [WGT_W-1:0]  prev_wgt;
    logic              prev_valid;
    logic [ECNT_W-1:0] cnt;
  } edge_outcome_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  keyed_edge_list_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  edge_op_t      edge_ops[$];
  edge_outcome_t outcomes_due[$];
  edge_op_t      cur_op;

  logic [KEY_W-1:0] nbr_key[CAPACITY];
  logic [WGT_W-1:0] nbr_wgt[CAPACITY];
  int               nbr_cnt = 0;

  int ops_total = 0;
  int ops_issued = 0;
  int outcomes_seen = 0;
  int mismatches = 0;
  int n_add = 0, n_upd = 0, n_rm = 0, n_nop = 0;
  int n_full = 0, n_warn = 0, peak_fill = 0;

  function automatic edge_outcome_t resolve_edge_op(edge_op_t r);
    edge_outcome_t res;
    int pos;
    pos = -1;
    res.status = ST_WARN;
    res.prev_wgt = '0;
    res.prev_valid = 1'b0;
    for (int i = 0; i < nbr_cnt; i++) begin
      if (pos < 0 && nbr_key[i] == r.key) pos = i;
    end
    case (r.func)
      FUNC_ADD: begin
        n_add++;
        if (pos >= 0) begin
          res.status = ST_WARN;
        end else if (nbr_cnt >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          nbr_key[nbr_cnt] = r.key;
          nbr_wgt[nbr_cnt] = r.weight;
          nbr_cnt++;
          res.status = ST_OK;
        end
      end
      FUNC_UPDATE: begin
        n_upd++;
        if (pos >= 0) begin
          res.prev_wgt = nbr_wgt[pos];
          res.prev_valid = 1'b1;
          nbr_wgt[pos] = r.weight;
          res.status = ST_OK;
        end
      end
      FUNC_REMOVE: begin
        n_rm++;
        if (pos >= 0) begin
          res.prev_wgt = nbr_wgt[pos];
          res.prev_valid = 1'b1;
          for (int i = pos; i + 1 < nbr_cnt; i++) begin
            nbr_key[i] = nbr_key[i + 1];
            nbr_wgt[i] = nbr_wgt[i + 1];
          end
          nbr_cnt--;
          res.status = ST_OK;
        end
      end
      default: n_nop++;
    endcase
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_WARN) n_warn++;
    if (nbr_cnt > peak_fill) peak_fill = nbr_cnt;
    res.cnt = ECNT_W'(nbr_cnt);
    return res;
  endfunction

  task automatic queue_op(func_t f, logic [KEY_W-1:0] k, logic [WGT_W-1:0] w, bit idle);
    edge_op_t r;
    r.func = f;
    r.key = k;
    r.weight = w;
    r.wait_idle = idle;
    edge_ops.push_back(r);
    ops_total++;
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        outcomes_due.push_back(resolve_edge_op(cur_op));
        ops_issued++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (edge_ops.size() != 0 && edge_ops[0].wait_idle &&
                     ops_issued != outcomes_seen + int'(out_tvalid && out_tready)) begin
          in_tvalid <= 1'b0;
        end else if (edge_ops.size() != 0) begin
          cur_op = edge_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_W-WGT_W-KEY_W-FUNC_W){1'b0}}, cur_op.weight, cur_op.key,
                       cur_op.func};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int hold_left = 0;
  int holds_done = 0;
  int phase_left = 0;
  int stall_pct = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done < 2 && outcomes_seen >= (holds_done == 0 ? 120 : 380)) begin
      holds_done++;
      hold_left = 80;
      out_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left = 64;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        phase_left--;
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    edge_outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      outcomes_seen <= outcomes_seen + 1;
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = outcomes_due.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_tdata[1:0]);
          mismatches++;
        end
        if (out_tdata[65:2] !== want.prev_wgt) begin
          $display("%0t: previous_weight expected %h, got %h", $time, want.prev_wgt,
                   out_tdata[65:2]);
          mismatches++;
        end
        if (out_tdata[66] !== want.prev_valid) begin
          $display("%0t: previous_valid expected %0d, got %0d", $time, want.prev_valid,
                   out_tdata[66]);
          mismatches++;
        end
        if (out_tdata[71:67] !== want.cnt) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, want.cnt,
                   out_tdata[71:67]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] key_pool[POOL_N];
    int bias;
    int roll;
    func_t f;
    logic [KEY_W-1:0] k;

    // fill to capacity, keys and weights at their extremes included
    queue_op(FUNC_ADD, '0, '0, 1'b0);
    queue_op(FUNC_ADD, KEY_MAX, {WGT_W{1'b1}}, 1'b0);
    for (int i = 1; i <= 14; i++) queue_op(FUNC_ADD, KEY_W'(i), {$urandom, $urandom}, 1'b0);
    queue_op(FUNC_ADD, KEY_W'(100), {$urandom, $urandom}, 1'b0);
    queue_op(FUNC_ADD, '0, {$urandom, $urandom}, 1'b0);
    queue_op(FUNC_UPDATE, KEY_MAX, '0, 1'b0);
    queue_op(FUNC_UPDATE, KEY_W'(12345), {$urandom, $urandom}, 1'b0);
    queue_op(FUNC_REMOVE, KEY_W'(5), '0, 1'b0);
    queue_op(FUNC_REMOVE, KEY_W'(5), '0, 1'b0);
    queue_op(FUNC_NOP, KEY_W'(1), {$urandom, $urandom}, 1'b0);
    queue_op(FUNC_REMOVE, '0, '0, 1'b0);
    queue_op(FUNC_REMOVE, KEY_W'(14), '0, 1'b0);

    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = KEY_W'($urandom);

    bias = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 60 == 0) bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      case (bias)
        0: f = (roll < 55) ? FUNC_ADD : (roll < 75) ? FUNC_UPDATE :
               (roll < 95) ? FUNC_REMOVE : FUNC_NOP;
        1: f = (roll < 35) ? FUNC_ADD : (roll < 65) ? FUNC_UPDATE :
               (roll < 95) ? FUNC_REMOVE : FUNC_NOP;
        default: f = (roll < 15) ? FUNC_ADD : (roll < 40) ? FUNC_UPDATE :
                     (roll < 95) ? FUNC_REMOVE : FUNC_NOP;
      endcase
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                       : KEY_W'($urandom);
      queue_op(f, k, {$urandom, $urandom}, (n == 0 || n == 275));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_issued != ops_total) @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests: %0d add, %0d update, %0d remove, %0d unused code",
             ops_total, n_add, n_upd, n_rm, n_nop);
    $display("%0d full rejects, %0d key warnings, peak fill %0d of %0d",
             n_full, n_warn, peak_fill, CAPACITY);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
